// ----- rtl/i2c_eeprom_slave_top_defines.svh -----
// ----------------------------------------------------------------------------
// i2c eeprom target assertion macros
// shared property wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_SLAVE_TOP_DEFINES_SVH
`define I2C_EEPROM_SLAVE_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define I2CEE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cee assertion failed");
// next-cycle implication
`define I2CEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cee assertion failed");
`else
`define I2CEE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define I2CEE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/i2cee_pkg.sv -----
// ----------------------------------------------------------------------------
// i2c eeprom target package
// bus event codes, status codes and widths shared by the interfaces and rtl
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ADDR7_W    = 7;
  localparam int unsigned PTR_W      = 8;
  localparam int unsigned PTR_SPAN   = 1 << PTR_W;
  localparam int unsigned MEM_DEPTH_DEF = 256;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 2;

  // apb register map
  localparam logic [APB_ADDR_W-1:0] REG_DEV_ADDR = '0;

  localparam logic [ADDR7_W-1:0] DEV_ADDR_RST = 7'd80;
  localparam logic [BYTE_W-1:0]  ERASED_BYTE  = 8'hff;
  localparam logic [BYTE_W-1:0]  REPLY_ACK    = 8'h01;
  localparam logic [BYTE_W-1:0]  REPLY_NONE   = 8'h00;

  // bus events
  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 3'd0,
    CMD_RESTART = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  // transfer status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_WR_IN_RD   = 2'd1,
    ST_RD_IN_WR   = 2'd2,
    ST_RD_NO_PTR  = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/i2cee_if.sv -----
// ----------------------------------------------------------------------------
// i2c eeprom target channel interfaces
// valid/ready channels for bus events in and replies out
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cee_in_if import i2cee_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface i2cee_out_if import i2cee_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   reply_byte;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output reply_byte, output status, input ready);
  modport sink   (input valid, input reply_byte, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/i2c_eeprom_slave_top.sv -----
// ----------------------------------------------------------------------------
// Byte-level I2C EEPROM target.
// in_ch carries one bus event per transfer (start, repeated start, stop,
// master writes a byte, master reads a byte); out_ch returns one reply per
// event: acknowledge flag or read data, plus a status code.
// The APB port holds the seven-bit device address (byte address 0).
// The reply to an accepted event passes the read stage register and then the
// output register before it is offered on out_ch. Throughput: one event per
// cycle while out_ch takes replies; flags and the word pointer are updated
// at acceptance, so the next event needs no wait, and a read after a write
// to the same cell sees the new byte since the write lands at the edge that
// accepts it, before the read is issued.
// Reset: all flags and the pointer clear, device address returns to 80 and
// per-cell valid bits clear, so every cell reads as 0xFF until written.
// No clearing pass is needed; events are taken from the first cycle.
// When out_ch stalls, the reply waits in the output register while a second
// event still enters the read stage; after that in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_eeprom_slave_top_defines.svh"

module i2c_eeprom_slave_top import i2cee_pkg::*; #(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  i2cee_in_if.sink                   in_ch,
  i2cee_out_if.source                out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned IDX_W = $clog2(MEM_DEPTH);

  // configuration
  logic [ADDR7_W-1:0] dev_addr_r;

  // transaction state
  logic             in_txn_r,   in_txn_nxt;
  logic             addr_seen_r, addr_seen_nxt;
  logic             selected_r, selected_nxt;
  logic             read_mode_r, read_mode_nxt;
  logic             ptr_valid_r, ptr_valid_nxt;
  logic [PTR_W-1:0] word_ptr_r, word_ptr_nxt;

  // storage
  logic [BYTE_W-1:0]    mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;

  // read stage
  logic              s1_valid_r;
  logic              s1_rd_r;
  logic [BYTE_W-1:0] s1_reply_r;
  status_t           s1_status_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_hit_r;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_reply_r;
  status_t           out_status_r;

  // event decode
  logic              in_fire;
  logic              out_free;
  logic              s1_move;
  logic              rd_en;
  logic              wr_en;
  logic [BYTE_W-1:0] reply0;
  status_t           status0;
  logic [IDX_W-1:0]  cell_idx;
  logic [IDX_W-1:0]  cell_tab [PTR_SPAN];

  // pointer to cell map, pointer modulo depth
  for (genvar g = 0; g < PTR_SPAN; g++) begin : g_cell
    localparam int unsigned CELL = g % MEM_DEPTH;
    assign cell_tab[g] = IDX_W'(CELL);
  end
  assign cell_idx = cell_tab[word_ptr_r];

  // handshakes
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_move      = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.reply_byte = out_reply_r;
  assign out_ch.status     = out_status_r;

  // apb
  assign pready = 1'b1;
  assign prdata = APB_DATA_W'(dev_addr_r);

  // event decode and state update
  always_comb begin
    in_txn_nxt    = in_txn_r;
    addr_seen_nxt = addr_seen_r;
    selected_nxt  = selected_r;
    read_mode_nxt = read_mode_r;
    ptr_valid_nxt = ptr_valid_r;
    word_ptr_nxt  = word_ptr_r;
    reply0        = REPLY_NONE;
    status0       = ST_OK;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    case (in_ch.command)
      CMD_START: begin
        in_txn_nxt    = 1'b1;
        ptr_valid_nxt = 1'b0;
        addr_seen_nxt = 1'b0;
        selected_nxt  = 1'b0;
      end
      CMD_RESTART: begin
        addr_seen_nxt = 1'b0;
        selected_nxt  = 1'b0;
      end
      CMD_STOP: begin
        in_txn_nxt = 1'b0;
      end
      CMD_WRITE: begin
        if (!in_txn_r) begin
          reply0 = REPLY_NONE;
        end else if (!addr_seen_r) begin
          addr_seen_nxt = 1'b1;
          if (in_ch.data_byte[BYTE_W-1:1] == dev_addr_r) begin
            selected_nxt  = 1'b1;
            read_mode_nxt = in_ch.data_byte[0];
            if (!in_ch.data_byte[0]) begin
              ptr_valid_nxt = 1'b0;
            end
            reply0 = REPLY_ACK;
          end
        end else if (!selected_r) begin
          reply0 = REPLY_NONE;
        end else if (read_mode_r) begin
          status0 = ST_WR_IN_RD;
        end else if (!ptr_valid_r) begin
          ptr_valid_nxt = 1'b1;
          word_ptr_nxt  = in_ch.data_byte;
          reply0        = REPLY_ACK;
        end else begin
          wr_en        = 1'b1;
          word_ptr_nxt = word_ptr_r + PTR_W'(1);
          reply0       = REPLY_ACK;
        end
      end
      CMD_READ: begin
        if (!in_txn_r || !addr_seen_r || !selected_r) begin
          reply0 = REPLY_NONE;
        end else if (!read_mode_r) begin
          status0 = ST_RD_IN_WR;
        end else if (!ptr_valid_r) begin
          status0 = ST_RD_NO_PTR;
        end else begin
          rd_en        = 1'b1;
          word_ptr_nxt = word_ptr_r + PTR_W'(1);
        end
      end
      default: begin
        reply0 = REPLY_NONE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RST;
      in_txn_r    <= 1'b0;
      addr_seen_r <= 1'b0;
      selected_r  <= 1'b0;
      read_mode_r <= 1'b0;
      ptr_valid_r <= 1'b0;
      word_ptr_r  <= '0;
      vld_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_DEV_ADDR) begin
        dev_addr_r <= pwdata[ADDR7_W-1:0];
      end
      if (in_fire) begin
        in_txn_r    <= in_txn_nxt;
        addr_seen_r <= addr_seen_nxt;
        selected_r  <= selected_nxt;
        read_mode_r <= read_mode_nxt;
        ptr_valid_r <= ptr_valid_nxt;
        word_ptr_r  <= word_ptr_nxt;
        if (wr_en) begin
          vld_r[cell_idx] <= 1'b1;
        end
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memory and read stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (wr_en) begin
        mem[cell_idx] <= in_ch.data_byte;
      end
      if (rd_en) begin
        rd_data_r <= mem[cell_idx];
        rd_hit_r  <= vld_r[cell_idx];
      end
      s1_rd_r     <= rd_en;
      s1_reply_r  <= reply0;
      s1_status_r <= status0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_move) begin
      if (s1_rd_r) begin
        out_reply_r <= rd_hit_r ? rd_data_r : ERASED_BYTE;
      end else begin
        out_reply_r <= s1_reply_r;
      end
      out_status_r <= s1_status_r;
    end
  end

  // checks
  `I2CEE_ASSERT_IMPLY(a_rw_excl, clk, rst_n, in_fire, !(rd_en && wr_en))
  `I2CEE_ASSERT_NEXT(a_rd_stage, clk, rst_n, in_fire && rd_en, s1_valid_r && s1_rd_r)
  `I2CEE_ASSERT_NEXT(a_wr_valid, clk, rst_n, in_fire && wr_en, vld_r[$past(cell_idx)])
  `I2CEE_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_r && !s1_move, s1_valid_r)
  `I2CEE_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid_r && out_status_r != ST_OK,
                      out_reply_r == REPLY_NONE)

endmodule

`default_nettype wire

// ----- bench/i2cee_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// i2c eeprom target reply tracker
// mirrors the target's bus state and memory, and keeps the replies that are
// still owed so each returned transfer can be checked against the oldest one
// ----------------------------------------------------------------------------
package i2cee_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cee_pkg::*;

  localparam int unsigned CELL_COUNT = MEM_DEPTH_DEF;

  typedef struct packed {
    logic [BYTE_W-1:0] reply_byte;
    status_t           status;
  } eeprom_reply_t;

  class reply_tracker;
    logic [ADDR7_W-1:0] device_address;
    bit                 in_txn;
    bit                 addr_seen;
    bit                 selected;
    bit                 read_mode;
    bit                 ptr_valid;
    logic [PTR_W-1:0]   word_ptr;
    logic [BYTE_W-1:0]  cells [CELL_COUNT];
    eeprom_reply_t      owed_replies [$];
    int unsigned        failures;
    int unsigned        replies_checked;

    function new();
      device_address  = DEV_ADDR_RST;
      in_txn          = 1'b0;
      addr_seen       = 1'b0;
      selected        = 1'b0;
      read_mode       = 1'b0;
      ptr_valid       = 1'b0;
      word_ptr        = '0;
      failures        = 0;
      replies_checked = 0;
      foreach (cells[i]) cells[i] = ERASED_BYTE;
    endfunction

    function void set_device_address(logic [ADDR7_W-1:0] value);
      device_address = value;
    endfunction

    function int unsigned outstanding();
      return owed_replies.size();
    endfunction

    // work out the reply to one accepted bus event and advance the target state
    function void note_event(logic [CMD_W-1:0] command, logic [BYTE_W-1:0] data_byte);
      eeprom_reply_t r;
      r.reply_byte = REPLY_NONE;
      r.status     = ST_OK;
      case (command)
        CMD_START: begin
          in_txn    = 1'b1;
          ptr_valid = 1'b0;
          addr_seen = 1'b0;
          selected  = 1'b0;
        end
        CMD_RESTART: begin
          addr_seen = 1'b0;
          selected  = 1'b0;
        end
        CMD_STOP: begin
          in_txn = 1'b0;
        end
        CMD_WRITE: begin
          if (in_txn) begin
            if (!addr_seen) begin
              // address byte: a mismatch leaves the direction alone
              addr_seen = 1'b1;
              if (data_byte[BYTE_W-1:1] == device_address) begin
                selected  = 1'b1;
                read_mode = data_byte[0];
                if (!read_mode) ptr_valid = 1'b0;
                r.reply_byte = REPLY_ACK;
              end
            end else if (selected) begin
              if (read_mode) begin
                r.status = ST_WR_IN_RD;
              end else if (!ptr_valid) begin
                ptr_valid    = 1'b1;
                word_ptr     = data_byte;
                r.reply_byte = REPLY_ACK;
              end else begin
                cells[word_ptr % CELL_COUNT] = data_byte;
                word_ptr     = word_ptr + 1'b1;
                r.reply_byte = REPLY_ACK;
              end
            end
          end
        end
        CMD_READ: begin
          if (in_txn && addr_seen && selected) begin
            if (!read_mode) begin
              r.status = ST_RD_IN_WR;
            end else if (!ptr_valid) begin
              r.status = ST_RD_NO_PTR;
            end else begin
              r.reply_byte = cells[word_ptr % CELL_COUNT];
              word_ptr     = word_ptr + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      owed_replies.push_back(r);
    endfunction

    // compare one returned transfer with the oldest owed reply
    function void check_reply(logic [BYTE_W-1:0] reply_byte, logic [STATUS_W-1:0] status);
      eeprom_reply_t want;
      if (owed_replies.size() == 0) begin
        $display("%0t: reply %02h status %0d arrived with no event outstanding",
                 $time, reply_byte, status);
        failures++;
        return;
      end
      want = owed_replies.pop_front();
      replies_checked++;
      if (reply_byte !== want.reply_byte) begin
        $display("%0t: reply_byte expected %02h, actual %02h",
                 $time, want.reply_byte, reply_byte);
        failures++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d (%s), actual %0d",
                 $time, want.status, want.status.name(), status);
        failures++;
      end
    endfunction
  endclass

endpackage

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// i2c eeprom target testbench
// drives bus events through the input channel and checks every reply against
// a behavioural mirror of the target; a directed opening covers each protocol
// corner, then random transactions run under several device addresses with
// random stalls on both channels, ending with a stretch of full throughput
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cee_pkg::*;
  import i2cee_tb_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PHASE_EVENTS  = 400;
  localparam int unsigned PHASE_COUNT   = 5;
  localparam int unsigned OPENING_COUNT = 28;

  localparam logic [CMD_W-1:0]      CMD_UNUSED_LO      = CMD_READ + 1'b1;
  localparam logic [CMD_W-1:0]      CMD_UNUSED_HI      = '1;
  localparam logic [BYTE_W-1:0]     RST_ADDR_WR        = {DEV_ADDR_RST, 1'b0};
  localparam logic [BYTE_W-1:0]     RST_ADDR_RD        = {DEV_ADDR_RST, 1'b1};

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;
  } bus_event_t;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  i2cee_in_if  in_bus ();
  i2cee_out_if out_bus ();

  reply_tracker tracker = new();

  int unsigned        gap_odds        = 0;
  int unsigned        stall_left      = 0;
  int unsigned        idle_cycles     = 0;
  int unsigned        events_sent     = 0;
  int unsigned        address_loads   = 0;
  logic [ADDR7_W-1:0] current_address = DEV_ADDR_RST;

  // protocol corners under the reset address
  bus_event_t opening_events [OPENING_COUNT] = '{
    '{CMD_READ,      8'h00},
    '{CMD_WRITE,     8'hff},
    '{CMD_UNUSED_LO, 8'h55},
    '{CMD_UNUSED_HI, 8'haa},
    '{CMD_START,     8'h00},
    '{CMD_READ,      8'h00},
    '{CMD_WRITE,     RST_ADDR_RD},
    '{CMD_READ,      8'h00},
    '{CMD_WRITE,     8'h00},
    '{CMD_RESTART,   8'h00},
    '{CMD_WRITE,     RST_ADDR_WR},
    '{CMD_READ,      8'h00},
    '{CMD_WRITE,     8'hff},
    '{CMD_WRITE,     8'h00},
    '{CMD_WRITE,     8'h5a},
    '{CMD_RESTART,   8'h00},
    '{CMD_WRITE,     RST_ADDR_WR},
    '{CMD_WRITE,     8'hff},
    '{CMD_RESTART,   8'h00},
    '{CMD_WRITE,     RST_ADDR_RD},
    '{CMD_READ,      8'h00},
    '{CMD_READ,      8'h00},
    '{CMD_READ,      8'h00},
    '{CMD_RESTART,   8'h00},
    '{CMD_WRITE,     8'h00},
    '{CMD_WRITE,     8'h12},
    '{CMD_READ,      8'h00},
    '{CMD_STOP,      8'h00}
  };

  i2c_eeprom_slave_top #(
    .MEM_DEPTH (MEM_DEPTH_DEF)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // reply channel back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else if (gap_odds != 0 && $urandom_range(gap_odds - 1) == 0) begin
      stall_left = $urandom_range(18);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        tracker.note_event(in_bus.command, in_bus.data_byte);
      if (out_bus.valid && out_bus.ready)
        tracker.check_reply(out_bus.reply_byte, out_bus.status);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d replies still owed",
                 $time, idle_cycles, tracker.outstanding());
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // one bus event, with an optional gap in front
  task automatic send_event(input logic [CMD_W-1:0] command,
                            input logic [BYTE_W-1:0] data_byte);
    if (gap_odds != 0 && $urandom_range(gap_odds - 1) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.command   <= command;
    in_bus.data_byte <= data_byte;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    events_sent++;
  endtask

  // hold the sender until every owed reply is back
  task automatic wait_for_replies();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // apb write of the device address, then read it back
  task automatic load_device_address(input logic [ADDR7_W-1:0] value);
    logic [APB_DATA_W-1:0] readback;
    wait_for_replies();
    repeat (2) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DEV_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_device_address(value);
    current_address = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[ADDR7_W-1:0] !== value) begin
      $display("%0t: device_address readback expected %0d, actual %0d",
               $time, value, readback[ADDR7_W-1:0]);
      tracker.failures++;
    end
    address_loads++;
  endtask

  // mostly our own address, now and then another target's
  function automatic logic [BYTE_W-1:0] address_byte(input bit read_dir);
    if ($urandom_range(9) == 0) return BYTE_W'($urandom);
    return {current_address, read_dir};
  endfunction

  task automatic random_transaction();
    int unsigned       kind;
    int unsigned       count;
    logic [BYTE_W-1:0] pointer;
    kind    = $urandom_range(9);
    count   = $urandom_range(8);
    pointer = $urandom_range(1) ? BYTE_W'($urandom_range(15)) : BYTE_W'($urandom);
    if (kind < 2) begin
      // noise: any event code with any byte
      repeat ($urandom_range(4, 1)) send_event(CMD_W'($urandom), BYTE_W'($urandom));
    end else if (kind < 6) begin
      // pointer set and burst write, often followed by a random read
      send_event($urandom_range(5) == 0 ? CMD_RESTART : CMD_START, BYTE_W'($urandom));
      send_event(CMD_WRITE, address_byte(1'b0));
      send_event(CMD_WRITE, pointer);
      repeat (count) send_event(CMD_WRITE, BYTE_W'($urandom));
      if ($urandom_range(1) != 0) begin
        send_event(CMD_RESTART, BYTE_W'($urandom));
        send_event(CMD_WRITE, address_byte(1'b1));
        repeat ($urandom_range(8, 1)) send_event(CMD_READ, BYTE_W'($urandom));
      end
      if ($urandom_range(3) != 0) send_event(CMD_STOP, BYTE_W'($urandom));
    end else if (kind < 8) begin
      // current-address read: the pointer survives a repeated start
      send_event(CMD_RESTART, BYTE_W'($urandom));
      send_event(CMD_WRITE, address_byte(1'b1));
      repeat (count + 1) send_event(CMD_READ, BYTE_W'($urandom));
      if ($urandom_range(1) != 0) send_event(CMD_STOP, BYTE_W'($urandom));
    end else begin
      // broken transfer: wrong-direction traffic, then a stray event after stop
      send_event(CMD_START, BYTE_W'($urandom));
      send_event(CMD_WRITE, address_byte(kind[0]));
      repeat (count)
        send_event($urandom_range(1) != 0 ? CMD_WRITE : CMD_READ, BYTE_W'($urandom));
      send_event(CMD_STOP, BYTE_W'($urandom));
      send_event($urandom_range(1) != 0 ? CMD_WRITE : CMD_READ, BYTE_W'($urandom));
    end
  endtask

  // stimulus
  initial begin
    logic [ADDR7_W-1:0] phase_address [PHASE_COUNT];
    int unsigned        phase_end;
    int unsigned        next_shuffle;
    int unsigned        pick;
    in_bus.valid     = 1'b0;
    in_bus.command   = CMD_START;
    in_bus.data_byte = '0;
    out_bus.ready    = 1'b0;
    phase_address    = '{7'd0, 7'd127, ADDR7_W'($urandom), ADDR7_W'($urandom), DEV_ADDR_RST};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening with light idling
    gap_odds = 4;
    foreach (opening_events[i])
      send_event(opening_events[i].command, opening_events[i].data_byte);

    // random phases, one device address each; the last runs flat out
    for (int p = 0; p < PHASE_COUNT; p++) begin
      load_device_address(phase_address[p]);
      phase_end    = events_sent + PHASE_EVENTS;
      next_shuffle = events_sent;
      while (events_sent < phase_end) begin
        if (p == PHASE_COUNT - 1) begin
          gap_odds = 0;
        end else if (events_sent >= next_shuffle) begin
          pick         = $urandom_range(3);
          gap_odds     = (pick == 0) ? 0 : (pick == 1) ? 2 : (pick == 2) ? 5 : 12;
          next_shuffle = events_sent + 100;
        end
        random_transaction();
      end
    end

    // drain and settle
    wait_for_replies();
    repeat (4) @(posedge clk);
    if (tracker.outstanding() != 0) begin
      $display("%0t: %0d replies never arrived", $time, tracker.outstanding());
      tracker.failures++;
    end

    $display("tb_top: %0d bus events sent, %0d replies checked", events_sent,
             tracker.replies_checked);
    $display("tb_top: %0d device address settings, 0 and 127 among them", address_loads);
    if (tracker.failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: %0d mismatches", tracker.failures);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
